/* hdl/dmec_pkg.sv */
// ----------------------------------------------------------------------------
// dmec_pkg
// Types and constants shared by the expiring direct-mapped cache modules.
// ----------------------------------------------------------------------------
package dmec_pkg;

    localparam int LINES_DEF      = 256;
    localparam int LINE_WORDS_DEF = 8;
    localparam int MAX_RESULTS    = 8;
    localparam logic [31:0] EXPIRY_RESET = 32'd1000;

    typedef enum logic [1:0] {
        KIND_WRITE  = 2'd0,
        KIND_LOOKUP = 2'd1,
        KIND_SWEEP  = 2'd2,
        KIND_NONE   = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] tag_id;
        logic [2:0]  word_index;
        logic [31:0] data_word;
        logic [31:0] now_ms;
    } t_in;

    typedef struct packed {
        logic        hit;
        logic [2:0]  out_word_index;
        logic [31:0] read_word;
        logic        last;
        logic [31:0] hit_count;
        logic [31:0] miss_count;
    } t_out;

    // One entry of the line metadata memory.
    typedef struct packed {
        logic        valid;
        logic [31:0] tag;
        logic [31:0] stamp;
    } t_meta;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_INDEX,
        S_CHECK,
        S_BURST,
        S_SWEEP
    } t_state;

endpackage

/* hdl/dmec_ram.sv */
// ----------------------------------------------------------------------------
// dmec_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module dmec_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/dmec_index.sv */
// ----------------------------------------------------------------------------
// dmec_index
// Line index unit: reduces a 32-bit tag modulo the line count.
// ----------------------------------------------------------------------------
module dmec_index #(
    parameter int LINES = dmec_pkg::LINES_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [31:0]              i_tag,
    output logic [$clog2(LINES)-1:0] o_line,
    output logic                     o_done
);

    localparam int IW = $clog2(LINES);

    generate
        if ((LINES & (LINES - 1)) == 0) begin : g_pow2
            logic [IW-1:0] r_line;
            logic          r_done;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_done <= 1'b0;
                end else if (i_start) begin
                    r_done <= 1'b1;
                end
                if (i_start) begin
                    r_line <= i_tag[IW-1:0];
                end
            end

            assign o_line = r_line;
            assign o_done = r_done;
        end else begin : g_fold
            // Remainder is built eight tag bits per cycle, most significant first.
            logic [31:0]   r_shr;
            logic [IW-1:0] r_rem;
            logic [2:0]    r_cnt;
            logic [IW-1:0] n_rem;

            always_comb begin
                logic [IW:0] rem_ext;
                rem_ext = {1'b0, r_rem};
                for (int k = 0; k < 8; k++) begin
                    rem_ext = {rem_ext[IW-1:0], r_shr[31-k]};
                    if (rem_ext >= (IW+1)'(LINES)) begin
                        rem_ext = rem_ext - (IW+1)'(LINES);
                    end
                end
                n_rem = rem_ext[IW-1:0];
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_cnt <= 3'd0;
                end else if (i_start) begin
                    r_cnt <= 3'd4;
                end else if (r_cnt != 3'd0) begin
                    r_cnt <= r_cnt - 3'd1;
                end
                if (i_start) begin
                    r_shr <= i_tag;
                    r_rem <= '0;
                end else if (r_cnt != 3'd0) begin
                    r_shr <= {r_shr[23:0], 8'd0};
                    r_rem <= n_rem;
                end
            end

            assign o_line = r_rem;
            assign o_done = (r_cnt == 3'd0);
        end
    endgenerate

endmodule

/* hdl/direct_mapped_expiring_cache.sv */
// ----------------------------------------------------------------------------
// direct_mapped_expiring_cache
// Direct-mapped cache with per-line idle timeout, hit and miss counters.
// ----------------------------------------------------------------------------
// Usage: present a word on i_item and raise start; it is taken on a clock edge
// where busy is low. A write stores one word of a line, a lookup returns the
// line's first min(LINE_WORDS, 8) words on a hit (one result per cycle, last
// on the final one) or one miss result; a sweep invalidates every line idle
// longer than the expiry register. Each result is on o_result for one cycle
// with o_result_vld high; the receiver cannot stall it. The user must write
// the expiry register with i_cfg_we only while the block is idle (unenforced).
// Timing: the result of a write, miss or unused kind follows acceptance through
// the index stage and the registered read of the line metadata memory. A hit
// yields min(LINE_WORDS, 8) words on consecutive cycles from the point where
// a miss result would appear, one word memory read each. A sweep reads the
// metadata of each line in turn and writes each stale one back invalid. When
// LINES is not a power of two, every item also waits for the tag reduction.
// Reset: a clearing pass over all LINES * LINE_WORDS word addresses zeroes both
// memories; busy stays high meanwhile.
// ----------------------------------------------------------------------------
module direct_mapped_expiring_cache #(
    parameter int LINES      = dmec_pkg::LINES_DEF,
    parameter int LINE_WORDS = dmec_pkg::LINE_WORDS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  dmec_pkg::t_in  i_item,
    output logic           o_result_vld,
    output dmec_pkg::t_out o_result,
    input  logic           i_cfg_we,
    input  logic [31:0]    i_cfg_wdata
);

    localparam int WD   = LINES * LINE_WORDS;
    localparam int MAW  = $clog2(LINES);
    localparam int WAW  = $clog2(WD);
    localparam int NRES = (LINE_WORDS < dmec_pkg::MAX_RESULTS) ?
                          LINE_WORDS : dmec_pkg::MAX_RESULTS;
    localparam logic [2:0] LAST_W = 3'(NRES - 1);

    dmec_pkg::t_state r_state, n_state;
    dmec_pkg::t_in    r_item, n_item;
    logic [2:0]       r_wcnt, n_wcnt;
    logic [MAW-1:0]   r_scnt, n_scnt;
    logic [WAW-1:0]   r_clr, n_clr;
    logic [31:0]      r_hits, n_hits;
    logic [31:0]      r_misses, n_misses;
    logic [31:0]      r_expiry;
    logic             r_res_vld, n_res_vld;
    dmec_pkg::t_out   r_res, n_res;

    logic             idx_start;
    logic [MAW-1:0]   line;
    logic             idx_done;
    logic [WAW-1:0]   base;

    logic             meta_we;
    logic [MAW-1:0]   meta_waddr, meta_raddr;
    dmec_pkg::t_meta  meta_wdata, meta_rdata;
    logic             word_we;
    logic [WAW-1:0]   word_waddr, word_raddr;
    logic [31:0]      word_wdata, word_rdata;

    assign idx_start = start && (r_state == dmec_pkg::S_IDLE);

    dmec_index #(.LINES(LINES)) u_index (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(idx_start),
        .i_tag  (i_item.tag_id),
        .o_line (line),
        .o_done (idx_done)
    );

    dmec_ram #(.WIDTH($bits(dmec_pkg::t_meta)), .DEPTH(LINES)) u_meta_ram (
        .i_clk  (i_clk),
        .i_we   (meta_we),
        .i_waddr(meta_waddr),
        .i_wdata(meta_wdata),
        .i_raddr(meta_raddr),
        .o_rdata(meta_rdata)
    );

    dmec_ram #(.WIDTH(32), .DEPTH(WD)) u_word_ram (
        .i_clk  (i_clk),
        .i_we   (word_we),
        .i_waddr(word_waddr),
        .i_wdata(word_wdata),
        .i_raddr(word_raddr),
        .o_rdata(word_rdata)
    );

    assign base = WAW'(line) * WAW'(LINE_WORDS);

    always_comb begin
        logic hit;
        hit       = meta_rdata.valid && (meta_rdata.tag == r_item.tag_id);
        n_state   = r_state;
        n_item    = r_item;
        n_wcnt    = r_wcnt;
        n_scnt    = r_scnt;
        n_clr     = r_clr;
        n_hits    = r_hits;
        n_misses  = r_misses;
        n_res_vld = 1'b0;
        n_res     = r_res;

        meta_we    = 1'b0;
        meta_waddr = line;
        meta_wdata = '{valid: 1'b1, tag: r_item.tag_id, stamp: r_item.now_ms};
        word_we    = 1'b0;
        word_waddr = base + WAW'(r_item.word_index);
        word_wdata = r_item.data_word;

        unique case (r_state)
            dmec_pkg::S_CLEAR: begin
                word_we    = 1'b1;
                word_waddr = r_clr;
                word_wdata = '0;
                meta_we    = ({1'b0, r_clr} < (WAW+1)'(LINES));
                meta_waddr = r_clr[MAW-1:0];
                meta_wdata = '0;
                n_clr      = r_clr + WAW'(1);
                if (r_clr == WAW'(WD - 1)) begin
                    n_state = dmec_pkg::S_IDLE;
                end
            end
            dmec_pkg::S_IDLE: begin
                if (start) begin
                    n_item  = i_item;
                    n_wcnt  = 3'd0;
                    n_state = dmec_pkg::S_INDEX;
                end
            end
            dmec_pkg::S_INDEX: begin
                if (idx_done) begin
                    n_state = dmec_pkg::S_CHECK;
                end
            end
            dmec_pkg::S_CHECK: begin
                // Default single result; a hit overrides it below, and a sweep holds it back until its pass ends.
                n_res.hit            = 1'b0;
                n_res.out_word_index = 3'd0;
                n_res.read_word      = '0;
                n_res.last           = 1'b1;
                n_res_vld            = 1'b1;
                n_state              = dmec_pkg::S_IDLE;
                unique case (r_item.kind)
                    dmec_pkg::KIND_WRITE: begin
                        if (7'(r_item.word_index) < 7'(LINE_WORDS)) begin
                            word_we = 1'b1;
                            meta_we = 1'b1;
                        end
                    end
                    dmec_pkg::KIND_LOOKUP: begin
                        if (hit) begin
                            meta_we              = 1'b1;
                            n_hits               = r_hits + 32'd1;
                            n_res.hit            = 1'b1;
                            n_res.read_word      = word_rdata;
                            n_res.last           = (LAST_W == 3'd0);
                            if (LAST_W != 3'd0) begin
                                n_wcnt  = 3'd1;
                                n_state = dmec_pkg::S_BURST;
                            end
                        end else begin
                            n_misses = r_misses + 32'd1;
                        end
                    end
                    dmec_pkg::KIND_SWEEP: begin
                        n_res_vld = 1'b0;
                        n_scnt    = '0;
                        n_state   = dmec_pkg::S_SWEEP;
                    end
                    dmec_pkg::KIND_NONE: begin
                    end
                    default: begin
                    end
                endcase
            end
            dmec_pkg::S_BURST: begin
                n_res.hit            = 1'b1;
                n_res.out_word_index = r_wcnt;
                n_res.read_word      = word_rdata;
                n_res.last           = (r_wcnt == LAST_W);
                n_res_vld            = 1'b1;
                n_wcnt               = r_wcnt + 3'd1;
                if (r_wcnt == LAST_W) begin
                    n_state = dmec_pkg::S_IDLE;
                end
            end
            dmec_pkg::S_SWEEP: begin
                // Read data belongs to line r_scnt; write it back invalid if stale.
                meta_waddr       = r_scnt;
                meta_wdata       = meta_rdata;
                meta_wdata.valid = 1'b0;
                meta_we          = meta_rdata.valid &&
                                   ((r_item.now_ms - meta_rdata.stamp) > r_expiry);
                n_scnt           = r_scnt + MAW'(1);
                if (r_scnt == MAW'(LINES - 1)) begin
                    n_res.hit            = 1'b0;
                    n_res.out_word_index = 3'd0;
                    n_res.read_word      = '0;
                    n_res.last           = 1'b1;
                    n_res_vld            = 1'b1;
                    n_state              = dmec_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = dmec_pkg::S_IDLE;
            end
        endcase

        n_res.hit_count  = n_hits;
        n_res.miss_count = n_misses;

        word_raddr = base + WAW'(n_wcnt);
        meta_raddr = (n_state == dmec_pkg::S_SWEEP) ? n_scnt : line;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= dmec_pkg::S_CLEAR;
            r_clr     <= '0;
            r_wcnt    <= 3'd0;
            r_scnt    <= '0;
            r_hits    <= '0;
            r_misses  <= '0;
            r_expiry  <= dmec_pkg::EXPIRY_RESET;
            r_res_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr     <= n_clr;
            r_wcnt    <= n_wcnt;
            r_scnt    <= n_scnt;
            r_hits    <= n_hits;
            r_misses  <= n_misses;
            r_res_vld <= n_res_vld;
            if (i_cfg_we) begin
                r_expiry <= i_cfg_wdata;
            end
        end
        r_item <= n_item;
        r_res  <= n_res;
    end

    assign busy         = (r_state != dmec_pkg::S_IDLE);
    assign o_result_vld = r_res_vld;
    assign o_result     = r_res;

endmodule

/* dv/direct_mapped_expiring_cache_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// direct_mapped_expiring_cache_tb
// Self-checking testbench for the expiring direct-mapped cache: directed
// writes, hits, misses, sweeps and expiry settings, then random line traffic
// with sender gaps, all scored against a cycle-free model of the cache.
// ----------------------------------------------------------------------------
module direct_mapped_expiring_cache_tb;

    localparam int WATCHDOG_LIMIT = 10000;
    localparam int POOL           = 8;

    logic                 i_clk;
    logic                 i_rst_n     = 1'b0;
    logic                 start       = 1'b0;
    logic                 busy;
    dmec_pkg::t_in        i_item      = '0;
    logic                 o_result_vld;
    dmec_pkg::t_out       o_result;
    logic                 i_cfg_we    = 1'b0;
    logic [31:0]          i_cfg_wdata = '0;

    direct_mapped_expiring_cache uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_item       (i_item),
        .o_result_vld (o_result_vld),
        .o_result     (o_result),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata)
    );

    // Shadow copy of the cache contents and counters.
    logic        shadow_valid [dmec_pkg::LINES_DEF];
    logic [31:0] shadow_tag   [dmec_pkg::LINES_DEF];
    logic [31:0] shadow_stamp [dmec_pkg::LINES_DEF];
    logic [31:0] shadow_words [dmec_pkg::LINES_DEF][dmec_pkg::LINE_WORDS_DEF];
    logic [31:0] shadow_hits;
    logic [31:0] shadow_misses;
    logic [31:0] shadow_expiry;

    dmec_pkg::t_out cache_results_due [$];
    dmec_pkg::t_out due_result;
    int             mismatch_count = 0;
    int             quiet_cycles   = 0;
    int             idle_pct       = 0;
    logic [31:0]    clock_ms;
    logic [31:0]    tag_pool [POOL];

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic dmec_pkg::t_in make_word(dmec_pkg::t_kind k, logic [31:0] tag,
                                                logic [2:0] idx, logic [31:0] data,
                                                logic [31:0] now);
        dmec_pkg::t_in w;
        w.kind       = k;
        w.tag_id     = tag;
        w.word_index = idx;
        w.data_word  = data;
        w.now_ms     = now;
        return w;
    endfunction

    function automatic void predict_cache_results(dmec_pkg::t_in w);
        int             line;
        int             n;
        dmec_pkg::t_out r;
        line = w.tag_id % dmec_pkg::LINES_DEF;
        n    = (dmec_pkg::LINE_WORDS_DEF < dmec_pkg::MAX_RESULTS) ?
               dmec_pkg::LINE_WORDS_DEF : dmec_pkg::MAX_RESULTS;
        case (w.kind)
            dmec_pkg::KIND_WRITE: begin
                if (w.word_index < dmec_pkg::LINE_WORDS_DEF) begin
                    shadow_words[line][w.word_index] = w.data_word;
                    shadow_tag[line]   = w.tag_id;
                    shadow_stamp[line] = w.now_ms;
                    shadow_valid[line] = 1'b1;
                end
            end
            dmec_pkg::KIND_LOOKUP: begin
                if (shadow_valid[line] && shadow_tag[line] == w.tag_id) begin
                    shadow_stamp[line] = w.now_ms;
                    shadow_hits += 1;
                    for (int i = 0; i < n; i++) begin
                        r.hit            = 1'b1;
                        r.out_word_index = 3'(i);
                        r.read_word      = shadow_words[line][i];
                        r.last           = (i == n - 1);
                        r.hit_count      = shadow_hits;
                        r.miss_count     = shadow_misses;
                        cache_results_due.push_back(r);
                    end
                    return;
                end
                shadow_misses += 1;
            end
            dmec_pkg::KIND_SWEEP: begin
                // Idle time wraps modulo 2^32; only strictly older lines expire.
                for (int i = 0; i < dmec_pkg::LINES_DEF; i++) begin
                    if (shadow_valid[i] && (w.now_ms - shadow_stamp[i]) > shadow_expiry)
                        shadow_valid[i] = 1'b0;
                end
            end
            default: ;
        endcase
        r.hit            = 1'b0;
        r.out_word_index = '0;
        r.read_word      = '0;
        r.last           = 1'b1;
        r.hit_count      = shadow_hits;
        r.miss_count     = shadow_misses;
        cache_results_due.push_back(r);
    endfunction

    // Must be entered right after a rising edge. Start is left high when no
    // gap follows, so the next word is taken on the first edge where busy is low.
    task automatic send_word(input dmec_pkg::t_in w);
        start  <= 1'b1;
        i_item <= w;
        do @(posedge i_clk); while (busy);
        predict_cache_results(w);
        if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
    endtask

    task automatic wait_drained;
        start <= 1'b0;
        while (cache_results_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_expiry(input logic [31:0] value);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        shadow_expiry = value;
    endtask

    task automatic test_write_and_hit;
        for (int i = 0; i < dmec_pkg::LINE_WORDS_DEF; i++)
            send_word(make_word(dmec_pkg::KIND_WRITE, 32'hFFFF_FFFF, 3'(i),
                                (i % 2) ? 32'hFFFF_FFFF : 32'h0000_0000, 32'h0));
        send_word(make_word(dmec_pkg::KIND_LOOKUP, 32'hFFFF_FFFF, 3'd0, 32'h0,
                            32'hFFFF_FFFF));
    endtask

    task automatic test_miss_cases;
        send_word(make_word(dmec_pkg::KIND_LOOKUP, 32'h0, 3'd0, 32'h0, 32'h10));
        // Same line as the tag of the first test, so its tag is replaced but words stay.
        send_word(make_word(dmec_pkg::KIND_WRITE, 32'h1234_56FF, 3'd3, 32'hA5A5_5A5A,
                            32'h20));
        send_word(make_word(dmec_pkg::KIND_LOOKUP, 32'hFFFF_FFFF, 3'd7, 32'hFFFF_FFFF,
                            32'h30));
        send_word(make_word(dmec_pkg::KIND_LOOKUP, 32'h1234_56FF, 3'd0, 32'h0, 32'h40));
    endtask

    task automatic test_unused_kind;
        send_word(make_word(dmec_pkg::KIND_NONE, 32'h1234_56FF, 3'd7, 32'hFFFF_FFFF,
                            32'hFFFF_FFFF));
        send_word(make_word(dmec_pkg::KIND_LOOKUP, 32'h1234_56FF, 3'd0, 32'h0, 32'h50));
    endtask

    task automatic test_sweep_expiry;
        set_expiry(32'h0);
        send_word(make_word(dmec_pkg::KIND_WRITE, 32'h5, 3'd1, 32'hDEAD_BEEF, 32'd100));
        send_word(make_word(dmec_pkg::KIND_SWEEP, 32'h0, 3'd0, 32'h0, 32'd100));
        send_word(make_word(dmec_pkg::KIND_LOOKUP, 32'h5, 3'd0, 32'h0, 32'd100));
        send_word(make_word(dmec_pkg::KIND_SWEEP, 32'h0, 3'd0, 32'h0, 32'd101));
        send_word(make_word(dmec_pkg::KIND_LOOKUP, 32'h5, 3'd0, 32'h0, 32'd101));
        set_expiry(32'hFFFF_FFFF);
        send_word(make_word(dmec_pkg::KIND_WRITE, 32'h6, 3'd2, 32'h1357_9BDF,
                            32'hFFFF_FFF0));
        // The idle time wraps past zero here and must still count as short.
        send_word(make_word(dmec_pkg::KIND_SWEEP, 32'hFFFF_FFFF, 3'd7, 32'hFFFF_FFFF,
                            32'h10));
        send_word(make_word(dmec_pkg::KIND_LOOKUP, 32'h6, 3'd0, 32'h0, 32'h20));
    endtask

    task automatic run_random_traffic(input int items, input int pct);
        int              sent;
        int              pick;
        int              nwords;
        int              nlook;
        logic [31:0]     tag;
        dmec_pkg::t_kind k;
        idle_pct = pct;
        sent     = 0;
        while (sent < items) begin
            clock_ms += $urandom_range(0, 400);
            if ($urandom_range(99) < 3)
                clock_ms = $urandom;
            pick = $urandom_range(99);
            tag  = tag_pool[$urandom_range(POOL - 1)];
            if (pick < 45) begin
                nwords = $urandom_range(1, dmec_pkg::LINE_WORDS_DEF);
                for (int i = 0; i < nwords; i++)
                    send_word(make_word(dmec_pkg::KIND_WRITE, tag,
                                        (nwords == dmec_pkg::LINE_WORDS_DEF) ?
                                        3'(i) : 3'($urandom),
                                        $urandom, clock_ms));
                nlook = $urandom_range(1, 2);
                for (int i = 0; i < nlook; i++)
                    send_word(make_word(dmec_pkg::KIND_LOOKUP, tag, 3'($urandom),
                                        $urandom, clock_ms + $urandom_range(0, 50)));
                sent += nwords + nlook;
            end else if (pick < 72) begin
                send_word(make_word(dmec_pkg::KIND_LOOKUP, tag, 3'($urandom), $urandom,
                                    clock_ms));
                sent++;
            end else if (pick < 82) begin
                send_word(make_word(dmec_pkg::KIND_SWEEP, $urandom, 3'($urandom),
                                    $urandom, clock_ms));
                sent++;
            end else begin
                k = dmec_pkg::t_kind'($urandom_range(3));
                send_word(make_word(k, $urandom, 3'($urandom), $urandom, $urandom));
                if (k != dmec_pkg::KIND_NONE)
                    sent++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if ((i_rst_n && start && !busy) || o_result_vld)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_result_vld) begin
            if (cache_results_due.size() == 0) begin
                if (mismatch_count < 10)
                    $display("unexpected result word %p", o_result);
                mismatch_count++;
            end else begin
                due_result = cache_results_due.pop_front();
                if (o_result.hit !== due_result.hit
                    || o_result.out_word_index !== due_result.out_word_index
                    || o_result.read_word !== due_result.read_word
                    || o_result.last !== due_result.last
                    || o_result.hit_count !== due_result.hit_count
                    || o_result.miss_count !== due_result.miss_count) begin
                    if (mismatch_count < 10)
                        $display("result mismatch: expected %p, got %p",
                                 due_result, o_result);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        for (int i = 0; i < dmec_pkg::LINES_DEF; i++) begin
            shadow_valid[i] = 1'b0;
            shadow_tag[i]   = '0;
            shadow_stamp[i] = '0;
            for (int j = 0; j < dmec_pkg::LINE_WORDS_DEF; j++)
                shadow_words[i][j] = '0;
        end
        shadow_hits   = '0;
        shadow_misses = '0;
        shadow_expiry = dmec_pkg::EXPIRY_RESET;
        clock_ms      = $urandom;
        // Pairs of tags share a line so that replacements and tag misses occur.
        for (int i = 0; i < POOL; i++)
            tag_pool[i] = {24'($urandom), 8'(i % (POOL / 2) * 37)};

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_write_and_hit();
        test_miss_cases();
        test_unused_kind();
        test_sweep_expiry();

        set_expiry(dmec_pkg::EXPIRY_RESET);
        run_random_traffic(50, 32);
        set_expiry($urandom_range(100, 3000));
        run_random_traffic(50, 58);
        set_expiry($urandom_range(100, 3000));
        run_random_traffic(50, 0);

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0 && cache_results_due.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
